// ===== sv/spt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, request codes and cell control struct for the sorted palette table.
// No dependencies; every other file imports this package.
package spt_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KIND_W     = 2;
  localparam int COLOR_W    = 24;
  localparam int INDEX_W    = 8;
  localparam int SLOT_W     = 8;
  localparam int USED_W     = 9;
  localparam int WIDE_W     = (CNT_W > INDEX_W + 1) ? CNT_W : INDEX_W + 1;
  localparam int GRP        = 16;
  localparam int NGRP       = (TABLE_SIZE + GRP - 1) / GRP;
  localparam int PAD_N      = NGRP * GRP;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_FIND  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [COLOR_W-1:0]  key;
    logic [INDEX_W-1:0]  index;
    logic [CNT_W-1:0]    count;
    logic                ins_en;
  } cell_ctl_t;

endpackage

// ===== sv/spt_in_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready plus kind, color and index of one request beat.
// Depends on spt_pkg.
interface spt_in_if;
  import spt_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COLOR_W-1:0] color;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output kind, output color, output index, input ready);
  modport sink   (input valid, input kind, input color, input index, output ready);
endinterface

// ===== sv/spt_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready plus ok, slot, entry_color and used_count of one result beat.
// Depends on spt_pkg.
interface spt_out_if;
  import spt_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [SLOT_W-1:0]  slot;
  logic [COLOR_W-1:0] entry_color;
  logic [USED_W-1:0]  used_count;

  modport source (output valid, output ok, output slot, output entry_color,
                  output used_count, input ready);
  modport sink   (input valid, input ok, input slot, input entry_color,
                  input used_count, output ready);
endinterface

// ===== sv/spt_cell.sv =====
`timescale 1ns / 1ps
// One table cell: holds one sorted entry, compares it with the broadcast key,
// and takes the key or its left neighbor's entry on insert. Depends on spt_pkg.
module spt_cell (
  input  logic                         clk,
  input  logic [spt_pkg::IDX_W-1:0]    cell_pos,
  input  spt_pkg::cell_ctl_t           ctl,
  input  logic [spt_pkg::COLOR_W-1:0]  prev_entry,
  input  logic                         prev_lt,
  output logic [spt_pkg::COLOR_W-1:0]  entry,
  output logic                         lt,
  output logic                         hit,
  output logic [spt_pkg::COLOR_W-1:0]  payload
);
  import spt_pkg::*;

  logic [COLOR_W-1:0] entry_r;
  logic [COLOR_W-1:0] entry_nxt;
  logic [WIDE_W-1:0]  pos_w;
  logic               valid;
  logic               eq;

  assign pos_w = WIDE_W'(cell_pos);
  assign valid = pos_w < WIDE_W'(ctl.count);
  assign lt    = valid && (entry_r < ctl.key);
  assign eq    = valid && (entry_r == ctl.key);
  assign entry = entry_r;

  always_comb begin
    case (ctl.kind)
      KIND_READ: begin
        hit     = valid && (pos_w == WIDE_W'(ctl.index));
        payload = entry_r;
      end
      default: begin
        hit     = eq;
        payload = COLOR_W'(pos_w[SLOT_W-1:0]);
      end
    endcase
  end

  // keep entries below the key, drop the key in at the boundary, shift the rest up
  assign entry_nxt = lt ? entry_r : (prev_lt ? ctl.key : prev_entry);

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== sv/sorted_palette_table_top.sv =====
`timescale 1ns / 1ps
// Sorted palette table: a row of compare-and-shift cells, a two-level hit reduction
// and a result register. Depends on spt_pkg, spt_in_if, spt_out_if and spt_cell.
//
// Usage:
//   in_ch carries one request per beat: kind (add, find, read, clear), color and index.
//   out_ch returns exactly one result beat per request: ok, slot, entry_color and
//   used_count, the number of distinct colors held after that request.
//   A request passes compare (every cell against the key at once), group reduction
//   over 16 cells, final reduction, then apply, where an add shifts the cells above
//   its sorted position up by one, all at once.
//   in_ch.ready is high only in IDLE, so a new request is taken only after the last
//   has left apply, even while its result still waits in the output register.
//   Reset (rst_n low, synchronous): the table is empty, no result is pending.
//   Entry contents are not cleared; only entries below the count are ever read.
//   A stalled receiver holds the result; a request that reaches apply behind it
//   waits there, and in_ch.ready stays low until it moves on.
module sorted_palette_table_top (
  input  logic      clk,
  input  logic      rst_n,
  spt_in_if.sink    in_ch,
  spt_out_if.source out_ch
);
  import spt_pkg::*;

  typedef enum logic [1:0] {IDLE, CMP, RED, APPLY} state_t;

  state_t             state_r;
  logic [KIND_W-1:0]  kind_r;
  logic [COLOR_W-1:0] key_r;
  logic [INDEX_W-1:0] index_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COLOR_W-1:0] out_entry_r;
  logic               ok_nxt;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [COLOR_W-1:0] entry_nxt;

  logic               in_fire;
  logic               apply_fire;
  logic               not_full;
  kind_t              kind;
  cell_ctl_t          ctl;

  logic [COLOR_W-1:0] cell_entry [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] cell_lt;
  logic [PAD_N-1:0]   cell_hit;
  logic [COLOR_W-1:0] cell_pay [PAD_N];

  logic [NGRP-1:0]    grp_hit_r;
  logic [NGRP-1:0]    grp_hit_nxt;
  logic [COLOR_W-1:0] grp_pay_r   [NGRP];
  logic [COLOR_W-1:0] grp_pay_nxt [NGRP];
  logic               red_hit_r;
  logic               red_hit_nxt;
  logic [COLOR_W-1:0] red_pay_r;
  logic [COLOR_W-1:0] red_pay_nxt;

  assign kind       = kind_t'(kind_r);
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign apply_fire = (state_r == APPLY) && (!out_valid_r || out_ch.ready);
  assign not_full   = count_r < CNT_W'(TABLE_SIZE);

  assign in_ch.ready = (state_r == IDLE);

  assign ctl.kind   = kind;
  assign ctl.key    = key_r;
  assign ctl.index  = index_r;
  assign ctl.count  = count_r;
  assign ctl.ins_en = apply_fire && (kind == KIND_ADD) && !red_hit_r && not_full;

  for (genvar i = 0; i < PAD_N; i++) begin : g_cell
    if (i < TABLE_SIZE) begin : g_real
      logic [COLOR_W-1:0] prev_entry;
      logic               prev_lt;
      if (i == 0) begin : g_first
        assign prev_entry = '0;
        assign prev_lt    = 1'b1;
      end else begin : g_rest
        assign prev_entry = cell_entry[i-1];
        assign prev_lt    = cell_lt[i-1];
      end
      spt_cell u_cell (
        .clk        (clk),
        .cell_pos   (IDX_W'(i)),
        .ctl        (ctl),
        .prev_entry (prev_entry),
        .prev_lt    (prev_lt),
        .entry      (cell_entry[i]),
        .lt         (cell_lt[i]),
        .hit        (cell_hit[i]),
        .payload    (cell_pay[i])
      );
    end else begin : g_pad
      assign cell_hit[i] = 1'b0;
      assign cell_pay[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = |cell_hit[g*GRP +: GRP];
      grp_pay_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_pay_nxt[g] = grp_pay_nxt[g] | (cell_pay[g*GRP + k] & {COLOR_W{cell_hit[g*GRP + k]}});
      end
    end
  end

  always_comb begin
    red_hit_nxt = |grp_hit_r;
    red_pay_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      red_pay_nxt = red_pay_nxt | grp_pay_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CMP) begin
      grp_hit_r <= grp_hit_nxt;
      grp_pay_r <= grp_pay_nxt;
    end
    if (state_r == RED) begin
      red_hit_r <= red_hit_nxt;
      red_pay_r <= red_pay_nxt;
    end
  end

  always_comb begin
    ok_nxt    = 1'b0;
    slot_nxt  = '0;
    entry_nxt = '0;
    count_nxt = count_r;
    case (kind)
      KIND_ADD: begin
        ok_nxt = red_hit_r || not_full;
        if (!red_hit_r && not_full) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_FIND: begin
        ok_nxt   = red_hit_r;
        slot_nxt = red_pay_r[SLOT_W-1:0];
      end
      KIND_READ: begin
        ok_nxt    = red_hit_r;
        entry_nxt = red_pay_r;
      end
      KIND_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        IDLE: begin
          if (in_fire) begin
            kind_r  <= in_ch.kind;
            key_r   <= in_ch.color;
            index_r <= in_ch.index;
            state_r <= CMP;
          end
        end
        CMP: begin
          state_r <= RED;
        end
        RED: begin
          state_r <= APPLY;
        end
        APPLY: begin
          if (apply_fire) begin
            state_r <= IDLE;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
      if (apply_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        out_ok_r    <= ok_nxt;
        out_slot_r  <= slot_nxt;
        out_entry_r <= entry_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.entry_color = out_entry_r;
  assign out_ch.used_count  = USED_W'(count_r);

`ifndef SYNTHESIS
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CMP) |-> $onehot0(cell_hit))
    else $error("more than one cell hit");

  a_beat_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == APPLY))
    else $error("result beat without apply");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == $past(count_r) + CNT_W'(1)) || (count_r == '0)))
    else $error("count moved by other than insert or clear");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == CMP))
    else $error("accepted request did not start compare");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |=> (count_r <= CNT_W'(TABLE_SIZE)) && !$past(red_hit_r))
    else $error("insert on full table or present color");
`endif

endmodule

// ===== bench/sorted_palette_table_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_palette_table_top: drives add, find, read and clear requests,
// predicts each result from its own copy of the sorted palette, and checks every result beat.
// Depends on spt_pkg, spt_in_if, spt_out_if and the sorted_palette_table_top RTL.
module sorted_palette_table_top_test;
  import spt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [COLOR_W-1:0] entry_color;
    logic [USED_W-1:0] used_count;
  } palette_result_t;

  logic clk;
  logic rst_n;

  spt_in_if  in_ch();
  spt_out_if out_ch();

  sorted_palette_table_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [COLOR_W-1:0] palette[TABLE_SIZE];
  int                 palette_count;
  palette_result_t    expected_results[$];

  int  mismatch_count;
  int  results_checked;
  int  requests_sent;
  int  kind_seen[4];
  int  full_add_rejects;
  int  cycle_count;
  int  stall_left;
  bit  steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
    $display("FAIL sorted_palette_table_top");
    $finish;
  end

  // Palette predictor: sorted distinct colors, count of held entries.
  function automatic palette_result_t apply_request(kind_t kind, logic [COLOR_W-1:0] color,
                                                    logic [INDEX_W-1:0] index);
    palette_result_t r;
    int              pos;
    int              i;
    bit              found;
    r = '0;
    case (kind)
      KIND_ADD, KIND_FIND: begin
        pos = 0;
        for (i = 0; i < palette_count; i++)
          if (palette[i] < color) pos++;
        found = (pos < palette_count) && (palette[pos] == color);
        if (kind == KIND_FIND) begin
          if (found) begin
            r.ok   = 1'b1;
            r.slot = pos[SLOT_W-1:0];
          end
        end else if (found) begin
          r.ok = 1'b1;
        end else if (palette_count < TABLE_SIZE) begin
          for (i = palette_count; i > pos; i--)
            palette[i] = palette[i-1];
          palette[pos] = color;
          palette_count++;
          r.ok = 1'b1;
        end else begin
          full_add_rejects++;
        end
      end
      KIND_READ: begin
        if (index < palette_count) begin
          r.ok          = 1'b1;
          r.entry_color = palette[index];
        end
      end
      default: begin
        palette_count = 0;
        r.ok          = 1'b1;
      end
    endcase
    r.used_count = palette_count[USED_W-1:0];
    return r;
  endfunction

  function automatic bit palette_holds(logic [COLOR_W-1:0] color);
    int i;
    for (i = 0; i < palette_count; i++)
      if (palette[i] == color) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int                 r;
    logic [COLOR_W-1:0] c;
    r = $urandom_range(0, 99);
    if (palette_count > 0 && r < 40) begin
      c = palette[$urandom_range(0, palette_count - 1)];
    end else if (palette_count > 0 && r < 55) begin
      c = palette[$urandom_range(0, palette_count - 1)];
      c = $urandom_range(0, 1) ? c + 1'b1 : c - 1'b1;
    end else if (r < 60) begin
      c = $urandom_range(0, 1) ? {COLOR_W{1'b1}} : '0;
    end else begin
      c = COLOR_W'($urandom);
    end
    return c;
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (palette_count > 0 && $urandom_range(0, 99) < 70)
      return INDEX_W'($urandom_range(0, palette_count - 1));
    return INDEX_W'($urandom);
  endfunction

  function automatic void compare_field(string name, logic [COLOR_W-1:0] want,
                                        logic [COLOR_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Send one request beat; predict its result at the accepting edge.
  task automatic send_request(kind_t kind, logic [COLOR_W-1:0] color,
                              logic [INDEX_W-1:0] index);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.color <= color;
    in_ch.index <= index;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results.push_back(apply_request(kind, color, index));
    requests_sent++;
    kind_seen[kind]++;
  endtask

  // Result sink with random back-pressure.
  always @(negedge clk) begin
    if (steady) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:19]:  stall_left = $urandom_range(1, 3);
        [20:22]: stall_left = $urandom_range(8, 40);
        default: stall_left = 0;
      endcase
    end
  end

  always @(posedge clk) begin
    palette_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: ok=%0b slot=%0d color=0x%0h used=%0d", $time,
                 out_ch.ok, out_ch.slot, out_ch.entry_color, out_ch.used_count);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("ok", COLOR_W'(want.ok), COLOR_W'(out_ch.ok));
        compare_field("slot", COLOR_W'(want.slot), COLOR_W'(out_ch.slot));
        compare_field("entry_color", want.entry_color, out_ch.entry_color);
        compare_field("used_count", COLOR_W'(want.used_count), COLOR_W'(out_ch.used_count));
        results_checked++;
      end
    end
  end

  task automatic test_empty_table();
    send_request(KIND_FIND, '0, '0);
    send_request(KIND_FIND, {COLOR_W{1'b1}}, '0);
    send_request(KIND_READ, '0, '0);
    send_request(KIND_READ, '0, {INDEX_W{1'b1}});
    send_request(KIND_CLEAR, '0, '0);
  endtask

  task automatic test_directed_ops();
    send_request(KIND_ADD, 24'h123456, '0);
    send_request(KIND_ADD, 24'h000000, '0);
    send_request(KIND_ADD, 24'hFFFFFF, 8'hFF);
    send_request(KIND_ADD, 24'h123456, '0);
    send_request(KIND_ADD, 24'hAAAAAA, 8'hAA);
    send_request(KIND_ADD, 24'h555555, 8'h55);
    send_request(KIND_ADD, 24'h123455, '0);
    send_request(KIND_FIND, 24'h123456, '0);
    send_request(KIND_FIND, 24'hFFFFFF, '0);
    send_request(KIND_FIND, 24'h000000, '0);
    send_request(KIND_FIND, 24'h000001, '0);
    send_request(KIND_READ, '0, 8'd0);
    send_request(KIND_READ, '0, 8'd5);
    send_request(KIND_READ, '0, 8'd6);
    send_request(KIND_READ, '0, 8'hFF);
    send_request(KIND_CLEAR, 24'hFFFFFF, 8'hFF);
    send_request(KIND_READ, '0, 8'd0);
    send_request(KIND_FIND, 24'h123456, '0);
    send_request(KIND_ADD, 24'h800000, '0);
    send_request(KIND_READ, '0, 8'd0);
  endtask

  task automatic test_full_table();
    logic [COLOR_W-1:0] c;
    send_request(KIND_CLEAR, '0, '0);
    while (palette_count < TABLE_SIZE)
      send_request(KIND_ADD, COLOR_W'($urandom), INDEX_W'($urandom));
    do c = COLOR_W'($urandom); while (palette_holds(c));
    send_request(KIND_ADD, c, '0);
    send_request(KIND_FIND, c, '0);
    send_request(KIND_ADD, palette[100], '0);
    send_request(KIND_ADD, palette[0], '0);
    send_request(KIND_ADD, palette[TABLE_SIZE-1], '0);
    send_request(KIND_FIND, palette[TABLE_SIZE-1], '0);
    send_request(KIND_FIND, palette[0], '0);
    send_request(KIND_READ, '0, 8'hFF);
    send_request(KIND_READ, '0, 8'h00);
    repeat (10) send_request(KIND_FIND, pick_color(), '0);
    send_request(KIND_CLEAR, '0, '0);
  endtask

  task automatic test_random_mix(int count);
    int   n;
    int   r;
    kind_t kind;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 299);
      if (r < 2) kind = KIND_CLEAR;
      else if (r < 128) kind = KIND_ADD;
      else if (r < 218) kind = KIND_FIND;
      else kind = KIND_READ;
      send_request(kind, pick_color(), pick_index());
    end
  endtask

  task automatic test_steady_stream(int count);
    steady = 1'b1;
    test_random_mix(count);
    steady = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_ADD;
    in_ch.color  = '0;
    in_ch.index  = '0;
    out_ch.ready = 1'b0;
    steady       = 1'b0;
    stall_left   = 0;
    cycle_count  = 0;
    palette_count = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_ops();
    test_full_table();
    test_steady_stream(150);
    test_random_mix(1100);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drained();

    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end
    $display("Sent %0d requests: %0d adds, %0d finds, %0d reads, %0d clears",
             requests_sent, kind_seen[KIND_ADD], kind_seen[KIND_FIND],
             kind_seen[KIND_READ], kind_seen[KIND_CLEAR]);
    $display("Checked %0d results, %0d adds rejected on a full table, %0d mismatches",
             results_checked, full_add_rejects, mismatch_count);
    if (mismatch_count == 0)
      $display("PASS sorted_palette_table_top");
    else
      $display("FAIL sorted_palette_table_top");
    $finish;
  end

endmodule

// ===== files.f =====
sv/spt_pkg.sv
sv/spt_in_if.sv
sv/spt_out_if.sv
sv/spt_cell.sv
sv/sorted_palette_table_top.sv
bench/sorted_palette_table_top_test.sv
